[sv/xtsta_pkg.sv]
// Shared types, constants and the byte-step function for the XTS tweak advance block.
`timescale 1ns / 1ps
`default_nettype none
package xtsta_pkg;

	localparam int HALF_W          = 64;
	localparam int BLK_W           = 2 * HALF_W;
	localparam int CNT_W           = 7;
	localparam int MAX_BYTE_SHIFTS = 64;
	localparam int BYTES_PER_STAGE = 8;
	localparam int STEP_W          = 4;
	localparam logic [7:0] REDUCTION_POLY = 8'h87;

	typedef struct packed {
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
		logic [CNT_W-1:0]  rem;
	} xtsta_item_t;

	// Multiply the block by x^(8*m), m up to eight; the bits that leave the top
	// fold back in once as their carry-less product with the polynomial.
	function automatic logic [BLK_W-1:0] xtsta_advance(input logic [BLK_W-1:0] blk,
			input logic [STEP_W-1:0] m);
		logic [BLK_W+HALF_W-1:0] wide;
		logic [BLK_W-1:0]        top;
		logic [BLK_W-1:0]        fold;
		wide = {{HALF_W{1'b0}}, blk} << {m, 3'b000};
		top  = {{(BLK_W-HALF_W){1'b0}}, wide[BLK_W+HALF_W-1:BLK_W]};
		fold = '0;
		for (int i = 0; i < 8; i++) begin
			if (REDUCTION_POLY[i]) begin
				fold = fold ^ (top << i);
			end
		end
		return wide[BLK_W-1:0] ^ fold;
	endfunction

endpackage
`default_nettype wire

[sv/xtsta_step.sv]
// One pipeline stage's worth of byte steps: up to eight, taken from the remaining count.
`timescale 1ns / 1ps
`default_nettype none
module xtsta_step (
	input  xtsta_pkg::xtsta_item_t item_in,
	output xtsta_pkg::xtsta_item_t item_out
);
	import xtsta_pkg::*;

	logic [STEP_W-1:0] m;

	always_comb begin
		if (item_in.rem > CNT_W'(BYTES_PER_STAGE)) begin
			m = STEP_W'(BYTES_PER_STAGE);
		end else begin
			m = item_in.rem[STEP_W-1:0];
		end
	end

	always_comb begin
		{item_out.hi, item_out.lo} = xtsta_advance({item_in.hi, item_in.lo}, m);
		item_out.rem = item_in.rem - CNT_W'(m);
	end

endmodule
`default_nettype wire

[sv/xtsta_cfg.sv]
// Byte step count register, saturated at the configured maximum.
`timescale 1ns / 1ps
`default_nettype none
module xtsta_cfg #(
	parameter int MAX_BYTE_SHIFTS = xtsta_pkg::MAX_BYTE_SHIFTS
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [xtsta_pkg::CNT_W-1:0] cfg_data,
	output logic [xtsta_pkg::CNT_W-1:0] steps
);
	import xtsta_pkg::*;

	logic [CNT_W-1:0] count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	always_comb begin
		if (32'(count_q) > MAX_BYTE_SHIFTS) begin
			steps = CNT_W'(MAX_BYTE_SHIFTS);
		end else begin
			steps = count_q;
		end
	end

endmodule
`default_nettype wire

[sv/xts_tweak_advance_by_x_power.sv]
// XTS tweak advance by x^(8k) in GF(2^128): top level and pipeline registers.
//
// Usage:
//   s_axis carries one 128-bit tweak block per transfer, m_axis the advanced
//   block. Each block is multiplied by x^(8k) modulo x^128+x^7+x^2+x+1, where
//   k is the byte step count written through the cfg channel (saturated at
//   MAX_BYTE_SHIFTS). Write cfg only while no block is in flight.
//   Each pipeline stage applies up to eight byte steps, one shift of up to
//   64 bits plus one fold of the bits that leave the top. Throughput is one
//   block per cycle while m_axis_tready is high. Every stage takes a new
//   block when it is empty or the stage after it moves on, so a stalled
//   receiver fills the pipeline first and only then drops s_axis_tready;
//   nothing is lost or sent twice.
//   Reset empties the pipeline and sets the step count to one.
`timescale 1ns / 1ps
`default_nettype none
module xts_tweak_advance_by_x_power #(
	parameter int MAX_BYTE_SHIFTS = xtsta_pkg::MAX_BYTE_SHIFTS
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire  [xtsta_pkg::BLK_W-1:0] s_axis_tdata,  // tweak_low, tweak_high
	output logic                        m_axis_tvalid,
	input  wire                         m_axis_tready,
	output logic [xtsta_pkg::BLK_W-1:0] m_axis_tdata,  // next_low, next_high
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [xtsta_pkg::CNT_W-1:0] cfg_data       // byte_shift_count
);
	import xtsta_pkg::*;

	localparam int NEED = (MAX_BYTE_SHIFTS + BYTES_PER_STAGE - 1) / BYTES_PER_STAGE;
	localparam int STG  = (NEED < 3) ? 3 : NEED;

	logic [CNT_W-1:0] steps;
	logic             rdy [STG+1];
	logic             valid_s [STG];
	xtsta_item_t      item_s [STG];
	xtsta_item_t      next_item [STG];
	xtsta_item_t      head;

	xtsta_cfg #(
		.MAX_BYTE_SHIFTS(MAX_BYTE_SHIFTS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.steps     (steps)
	);

	always_comb begin
		head.lo  = s_axis_tdata[HALF_W-1:0];
		head.hi  = s_axis_tdata[BLK_W-1:HALF_W];
		head.rem = steps;
	end

	assign rdy[STG]      = m_axis_tready;
	assign s_axis_tready = rdy[0];

	for (genvar i = 0; i < STG; i++) begin : g_stage
		xtsta_step u_step (
			.item_in  ((i == 0) ? head : item_s[(i == 0) ? 0 : i-1]),
			.item_out (next_item[i])
		);

		assign rdy[i] = !valid_s[i] || rdy[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				valid_s[i] <= (i == 0) ? s_axis_tvalid : valid_s[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i]) begin
				item_s[i] <= next_item[i];
			end
		end
	end

	assign m_axis_tvalid = valid_s[STG-1];
	assign m_axis_tdata  = {item_s[STG-1].hi, item_s[STG-1].lo};

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the XTS tweak advance by x^(8k) stream block.
`timescale 1ns / 1ps
module testbench;
	import xtsta_pkg::*;

	localparam int          HALF_PERIOD = 5;
	localparam int          SETTLE_CYC  = 16;
	localparam logic [7:0]  FOLD_POLY   = 8'h87;
	localparam int          RAND_CHUNKS = 11;
	localparam int          CHUNK_ITEMS = 50;
	localparam int          N_DIRECTED  = 22;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic              fixed;
		logic [HALF_W-1:0] lo;
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] exp_lo;
		logic [HALF_W-1:0] exp_hi;
	} tweak_row_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [BLK_W-1:0]  s_axis_tdata  = '0;  // tweak_low, tweak_high
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [BLK_W-1:0]  m_axis_tdata;        // next_low, next_high
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data      = '0;

	// sideband travelling with tdata: a typed-in result for directed rows
	logic              row_fixed     = 1'b0;
	logic [BLK_W-1:0]  row_result    = '0;

	idle_mode_t        idle_mode     = IDLE_NONE;
	logic [CNT_W-1:0]  shift_count   = 7'd1;  // as seen by the block, updated on cfg transfer
	logic [CNT_W-1:0]  cfg_written   = 7'd1;  // driver side copy
	logic [BLK_W-1:0]  pending_tweaks[$];     // {next_high, next_low}
	int                mismatch_count = 0;
	tweak_row_t        dir_rows[N_DIRECTED];

	xts_tweak_advance_by_x_power u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Multiply {hi,lo} by x^(8*cnt), byte at a time, count saturating at the maximum.
	function automatic logic [BLK_W-1:0] advance_tweak(input logic [HALF_W-1:0] lo,
			input logic [HALF_W-1:0] hi, input logic [CNT_W-1:0] cnt);
		logic [HALF_W-1:0] l;
		logic [HALF_W-1:0] h;
		logic [7:0]        top;
		logic [15:0]       fold;
		int                steps;
		l = lo;
		h = hi;
		steps = (int'(cnt) > MAX_BYTE_SHIFTS) ? MAX_BYTE_SHIFTS : int'(cnt);
		for (int s = 0; s < steps; s++) begin
			top  = h[63:56];
			h    = {h[55:0], l[63:56]};
			fold = '0;
			for (int b = 0; b < 8; b++) begin
				if (top[b]) begin
					fold = fold ^ ({8'h00, FOLD_POLY} << b);
				end
			end
			l = {l[55:0], 8'h00} ^ {48'h0, fold};
		end
		return {h, l};
	endfunction

	function automatic int send_idle_pct(input idle_mode_t m);
		return (m == IDLE_SEND) ? 78 : (m == IDLE_BOTH) ? 14 : 0;
	endfunction

	function automatic int recv_stall_pct(input idle_mode_t m);
		return (m == IDLE_RECV) ? 78 : (m == IDLE_BOTH) ? 14 : 0;
	endfunction

	// Random halves: dense random, sparse, zero, all-ones, one-hot and top-byte-only patterns.
	function automatic logic [HALF_W-1:0] rand_half();
		logic [HALF_W-1:0] v;
		case ($urandom_range(0, 7))
			0: begin
				v = '0;
			end
			1: begin
				v = '1;
			end
			2: begin
				v = 64'd1 << $urandom_range(0, 63);
			end
			3: begin
				v = {8'($urandom_range(0, 255)), 56'h0};  // only the byte that folds
			end
			4: begin
				v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			end
			default: begin
				v = {$urandom, $urandom};
			end
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [HALF_W-1:0] exp_v,
			input logic [HALF_W-1:0] act_v);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch %0s at %0t: expected %h, got %h", what, $time, exp_v, act_v);
		end
	endtask

	// Scoreboard: record expectations on input transfer, compare on output transfer.
	always @(posedge clk) begin
		logic [BLK_W-1:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				shift_count <= cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (row_fixed) begin
					pending_tweaks.push_back(row_result);
				end else begin
					pending_tweaks.push_back(advance_tweak(s_axis_tdata[63:0],
							s_axis_tdata[127:64], shift_count));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_tweaks.size() == 0) begin
					report_mismatch("unexpected result, next_low", '0, m_axis_tdata[63:0]);
				end else begin
					want = pending_tweaks.pop_front();
					if (m_axis_tdata[63:0] !== want[63:0]) begin
						report_mismatch("next_low", want[63:0], m_axis_tdata[63:0]);
					end
					if (m_axis_tdata[127:64] !== want[127:64]) begin
						report_mismatch("next_high", want[127:64], m_axis_tdata[127:64]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (recv_stall_pct(idle_mode) == 0) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct(idle_mode));
		end
	end

	task automatic send_tweak(input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi,
			input logic fixed, input logic [BLK_W-1:0] result);
		while ($urandom_range(0, 99) < send_idle_pct(idle_mode)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {hi, lo};
		row_fixed     <= fixed;
		row_result    <= result;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	// Stop sending and wait for every outstanding block, then let the pipeline settle.
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_tweaks.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_shift_count(input logic [CNT_W-1:0] v);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid   <= 1'b0;
		cfg_written = v;
	endtask

	initial begin
		logic [CNT_W-1:0] chunk_cfg[RAND_CHUNKS];
		tweak_row_t       row;
		// count, fixed, lo, hi, expected lo, expected hi
		dir_rows = '{
			'{7'd1,   1'b1, 64'h0, 64'h0, 64'h0, 64'h0},
			'{7'd1,   1'b1, 64'h1, 64'h0, 64'h100, 64'h0},
			'{7'd1,   1'b1, 64'h0, 64'h0100_0000_0000_0000, 64'h87, 64'h0},
			'{7'd1,   1'b1, 64'hFF00_0000_0000_0000, 64'h0, 64'h0, 64'hFF},
			'{7'd1,   1'b0, '1, '1, 64'h0, 64'h0},
			'{7'd1,   1'b0, 64'h0, 64'hFF00_0000_0000_0000, 64'h0, 64'h0},
			// zero count passes the block through
			'{7'd0,   1'b1, '1, '1, '1, '1},
			'{7'd0,   1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
				64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210},
			'{7'd16,  1'b1, 64'h1, 64'h0, 64'h87, 64'h0},
			'{7'd16,  1'b0, '1, '1, 64'h0, 64'h0},
			'{7'd64,  1'b1, 64'h0, 64'h0, 64'h0, 64'h0},
			'{7'd64,  1'b0, '1, '1, 64'h0, 64'h0},
			'{7'd64,  1'b0, 64'h1, 64'h0, 64'h0, 64'h0},
			'{7'd64,  1'b0, 64'hDEAD_BEEF_CAFE_F00D, 64'h1234_5678_9ABC_DEF0, 64'h0, 64'h0},
			// counts above the maximum saturate
			'{7'd127, 1'b0, '1, '1, 64'h0, 64'h0},
			'{7'd127, 1'b0, 64'h1, 64'h0, 64'h0, 64'h0},
			'{7'd127, 1'b0, 64'h0, 64'h8000_0000_0000_0000, 64'h0, 64'h0},
			'{7'd65,  1'b0, '1, '1, 64'h0, 64'h0},
			'{7'd65,  1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 64'h0},
			'{7'd8,   1'b1, 64'h1, 64'h0, 64'h0, 64'h1},
			'{7'd8,   1'b1, 64'h0, 64'h1, 64'h87, 64'h0},
			'{7'd8,   1'b1, '1, 64'h0, 64'h0, '1}
		};
		chunk_cfg = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd8, 7'd65,
			7'(1 + $urandom_range(0, 63)), 7'($urandom_range(0, 127)), 7'd16, 7'd2, 7'd63};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, first ones at the reset count
		for (int r = 0; r < N_DIRECTED; r++) begin
			row = dir_rows[r];
			if (row.cnt != cfg_written) begin
				write_shift_count(row.cnt);
			end
			send_tweak(row.lo, row.hi, row.fixed, {row.exp_hi, row.exp_lo});
		end

		for (int c = 0; c < RAND_CHUNKS; c++) begin
			write_shift_count(chunk_cfg[c]);
			idle_mode = idle_mode_t'(c % 4);
			for (int i = 0; i < CHUNK_ITEMS; i++) begin
				if (c == 5 && i == CHUNK_ITEMS / 2) begin
					drain_pipeline();  // hold off until the pipeline is empty
				end
				send_tweak(rand_half(), rand_half(), 1'b0, '0);
			end
		end

		idle_mode = IDLE_NONE;
		drain_pipeline();
		if (mismatch_count == 0) begin
			$display("PASS xts_tweak_advance_by_x_power");
		end else begin
			$display("FAIL xts_tweak_advance_by_x_power");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL xts_tweak_advance_by_x_power");
		$finish;
	end

endmodule
